// ----- src/tcba_pkg.sv -----
package tcba_pkg;

   localparam int ADDR_W    = 16;
   localparam int SIZE_W    = 12;
   localparam int MAP_W     = 5;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_W     = 16;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_SMALL_POOL_BASE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LARGE_POOL_BASE = 1'd1;

   localparam logic [ADDR_W-1:0] SMALL_POOL_BASE_RESET = 16'd0;
   localparam logic [ADDR_W-1:0] LARGE_POOL_BASE_RESET = 16'd1024;

   typedef enum logic [1:0] {
      STATUS_OK            = 2'd0,
      STATUS_TOO_LARGE     = 2'd1,
      STATUS_EXHAUSTED     = 2'd2,
      STATUS_NOT_ALLOCATED = 2'd3
   } status_type;

endpackage

// ----- src/two_class_block_allocator.sv -----
// Two-class fixed-block allocator, one request per clock unless the response side stalls.
// A request accepted into the input register passes through the decision logic
// into the response register.
// Throughput: one request per cycle unless rsp_ready stalls; the busy bitmaps update in
// the same cycle a request moves into the response register, so back-to-back requests chain.
// Reset (synchronous): both bitmaps cleared, pool bases at 0 and 1024.
module two_class_block_allocator #(
   parameter int SMALL_BLOCKS      = 5,
   parameter int LARGE_BLOCKS      = 5,
   parameter int SMALL_BLOCK_BYTES = 128,
   parameter int LARGE_BLOCK_BYTES = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_mode,
   input  logic [tcba_pkg::SIZE_W-1:0]          req_size,
   input  logic [tcba_pkg::ADDR_W-1:0]          req_release_addr,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [tcba_pkg::ADDR_W-1:0]          rsp_grant_addr,
   output tcba_pkg::status_type                 rsp_status,
   output logic [tcba_pkg::MAP_W-1:0]           rsp_small_busy_map,
   output logic [tcba_pkg::MAP_W-1:0]           rsp_large_busy_map,
   input  logic                                 csr_we,
   input  logic [tcba_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [tcba_pkg::CSR_W-1:0]           csr_wdata
);
   import tcba_pkg::*;

   // Index widths for each pool; a single-block pool still needs one bit.
   localparam int SI_W = (SMALL_BLOCKS > 1) ? $clog2(SMALL_BLOCKS) : 1;
   localparam int LI_W = (LARGE_BLOCKS > 1) ? $clog2(LARGE_BLOCKS) : 1;
   // Size thresholds are compared one bit wider so that 4096 is representable.
   localparam int CMP_W = SIZE_W + 1;
   localparam logic [CMP_W-1:0] SMALL_LIMIT = CMP_W'(SMALL_BLOCK_BYTES);
   localparam logic [CMP_W-1:0] LARGE_LIMIT = CMP_W'(LARGE_BLOCK_BYTES);

   // Configuration registers.
   logic [ADDR_W-1:0] small_base_ff, small_base_in;
   logic [ADDR_W-1:0] large_base_ff, large_base_in;

   // Input register stage.
   logic              in_valid_ff, in_valid_in;
   logic              in_mode_ff;
   logic [SIZE_W-1:0] in_size_ff;
   logic [ADDR_W-1:0] in_addr_ff;

   // Allocation state.
   logic [SMALL_BLOCKS-1:0] small_busy_ff, small_busy_in;
   logic [LARGE_BLOCKS-1:0] large_busy_ff, large_busy_in;

   // Response register stage.
   logic              out_valid_ff, out_valid_in;
   logic [ADDR_W-1:0] out_grant_ff, out_grant_in;
   status_type        out_status_ff, out_status_in;
   logic [MAP_W-1:0]  out_small_map_ff, out_small_map_in;
   logic [MAP_W-1:0]  out_large_map_ff, out_large_map_in;

   logic req_accept;
   logic advance;

   // The held request moves on whenever the response register is empty or
   // being drained this cycle; the input register refills in the same cycle.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready  = !in_valid_ff || advance;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // Configuration decode. Write only while the block is idle; the block itself does not enforce this.
   always_comb begin
      small_base_in = small_base_ff;
      large_base_in = large_base_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SMALL_POOL_BASE: small_base_in = csr_wdata;
            CSR_LARGE_POOL_BASE: large_base_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // Allocation side: lowest free block of each pool.
   logic [SI_W-1:0] small_free_idx;
   logic [LI_W-1:0] large_free_idx;
   logic            small_full;
   logic            large_full;

   always_comb begin
      small_free_idx = '0;
      for (int k = SMALL_BLOCKS - 1; k >= 0; k--) begin
         if (!small_busy_ff[k]) begin
            small_free_idx = SI_W'(k);
         end
      end
      large_free_idx = '0;
      for (int k = LARGE_BLOCKS - 1; k >= 0; k--) begin
         if (!large_busy_ff[k]) begin
            large_free_idx = LI_W'(k);
         end
      end
   end

   assign small_full = &small_busy_ff;
   assign large_full = &large_busy_ff;

   logic [ADDR_W-1:0] small_grant_addr;
   logic [ADDR_W-1:0] large_grant_addr;

   assign small_grant_addr = small_base_ff + ADDR_W'(small_free_idx * SMALL_BLOCK_BYTES);
   assign large_grant_addr = large_base_ff + ADDR_W'(large_free_idx * LARGE_BLOCK_BYTES);

   // Release side: every block compares its own address against the request.
   // Only busy blocks count as hits; the lowest hit in a pool is released,
   // and the small pool wins over the large one.
   logic [SMALL_BLOCKS-1:0] small_hit, small_clear;
   logic [LARGE_BLOCKS-1:0] large_hit, large_clear;

   always_comb begin
      for (int k = 0; k < SMALL_BLOCKS; k++) begin
         small_hit[k] = small_busy_ff[k] &&
            ((small_base_ff + ADDR_W'(k * SMALL_BLOCK_BYTES)) == in_addr_ff);
      end
      for (int k = 0; k < LARGE_BLOCKS; k++) begin
         large_hit[k] = large_busy_ff[k] &&
            ((large_base_ff + ADDR_W'(k * LARGE_BLOCK_BYTES)) == in_addr_ff);
      end
   end

   // Isolate the lowest set bit of each hit vector.
   assign small_clear = small_hit & (~small_hit + SMALL_BLOCKS'(1));
   assign large_clear = large_hit & (~large_hit + LARGE_BLOCKS'(1));

   // Decision for the request in the input register.
   logic [CMP_W-1:0] size_ext;
   logic [31:0]      small_map_ext;
   logic [31:0]      large_map_ext;

   assign size_ext = {1'b0, in_size_ff};

   always_comb begin
      small_busy_in = small_busy_ff;
      large_busy_in = large_busy_ff;
      out_grant_in  = '0;
      out_status_in = STATUS_OK;
      case (in_mode_ff)
         MODE_ALLOC: begin
            if (size_ext <= SMALL_LIMIT) begin
               if (small_full) begin
                  out_status_in = STATUS_EXHAUSTED;
               end else begin
                  small_busy_in[small_free_idx] = 1'b1;
                  out_grant_in = small_grant_addr;
               end
            end else if (size_ext <= LARGE_LIMIT) begin
               if (large_full) begin
                  out_status_in = STATUS_EXHAUSTED;
               end else begin
                  large_busy_in[large_free_idx] = 1'b1;
                  out_grant_in = large_grant_addr;
               end
            end else begin
               out_status_in = STATUS_TOO_LARGE;
            end
         end
         default: begin
            if (|small_hit) begin
               small_busy_in = small_busy_ff & ~small_clear;
            end else if (|large_hit) begin
               large_busy_in = large_busy_ff & ~large_clear;
            end else begin
               out_status_in = STATUS_NOT_ALLOCATED;
            end
         end
      endcase
      small_map_ext    = 32'(small_busy_in);
      large_map_ext    = 32'(large_busy_in);
      out_small_map_in = small_map_ext[MAP_W-1:0];
      out_large_map_in = large_map_ext[MAP_W-1:0];
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         small_busy_ff <= '0;
         large_busy_ff <= '0;
         small_base_ff <= SMALL_POOL_BASE_RESET;
         large_base_ff <= LARGE_POOL_BASE_RESET;
      end else begin
         in_valid_ff   <= in_valid_in;
         out_valid_ff  <= out_valid_in;
         small_base_ff <= small_base_in;
         large_base_ff <= large_base_in;
         if (advance) begin
            small_busy_ff <= small_busy_in;
            large_busy_ff <= large_busy_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_mode_ff <= req_mode;
         in_size_ff <= req_size;
         in_addr_ff <= req_release_addr;
      end
      if (advance) begin
         out_grant_ff     <= out_grant_in;
         out_status_ff    <= out_status_in;
         out_small_map_ff <= out_small_map_in;
         out_large_map_ff <= out_large_map_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_grant_addr     = out_grant_ff;
   assign rsp_status         = out_status_ff;
   assign rsp_small_busy_map = out_small_map_ff;
   assign rsp_large_busy_map = out_large_map_ff;

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps

module tb;
   import tcba_pkg::*;

   // The block is built with its default geometry and the predictor below uses the same
   // numbers.
   localparam int SMALL_BLOCKS      = 5;
   localparam int LARGE_BLOCKS      = 5;
   localparam int SMALL_BLOCK_BYTES = 128;
   localparam int LARGE_BLOCK_BYTES = 256;

   // A correct run never goes this many cycles without a request or a response moving.
   localparam int QUIET_LIMIT = 2000;
   localparam int PHASE_ITEMS = 320;

   // One response as seen on the rsp_ channel.
   typedef struct packed {
      logic [ADDR_W-1:0] grant;
      status_type        status;
      logic [MAP_W-1:0]  small_map;
      logic [MAP_W-1:0]  large_map;
   } alloc_result_type;

   // The scoreboard keeps its own copy of the pool bases and busy bitmaps. Every accepted
   // request advances that copy and queues the response it must produce, and every
   // response is compared with the oldest queued one.
   class alloc_scoreboard;
      logic [ADDR_W-1:0] small_base;
      logic [ADDR_W-1:0] large_base;
      logic [31:0]       small_busy;
      logic [31:0]       large_busy;
      alloc_result_type  expected_q[$];
      int                mismatches;
      int                requests;
      int                responses;
      int                status_seen[4];

      function new();
         small_base = SMALL_POOL_BASE_RESET;
         large_base = LARGE_POOL_BASE_RESET;
         small_busy = '0;
         large_busy = '0;
         mismatches = 0;
         requests   = 0;
         responses  = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
      endfunction

      function void write_base(logic [CSR_IDX_W-1:0] index, logic [CSR_W-1:0] value);
         if (index == CSR_SMALL_POOL_BASE) small_base = value;
         else if (index == CSR_LARGE_POOL_BASE) large_base = value;
      endfunction

      function int pool_blocks(bit large_pool);
         return large_pool ? LARGE_BLOCKS : SMALL_BLOCKS;
      endfunction

      // Block addresses wrap at 64 KiB.
      function logic [ADDR_W-1:0] pool_address(bit large_pool, int idx);
         logic [31:0] sum;
         if (large_pool) sum = 32'(large_base) + 32'(idx * LARGE_BLOCK_BYTES);
         else sum = 32'(small_base) + 32'(idx * SMALL_BLOCK_BYTES);
         return sum[ADDR_W-1:0];
      endfunction

      function bit is_busy(bit large_pool, int idx);
         return large_pool ? large_busy[idx] : small_busy[idx];
      endfunction

      function int lowest_free(bit large_pool);
         for (int k = 0; k < pool_blocks(large_pool); k++)
            if (!is_busy(large_pool, k)) return k;
         return -1;
      endfunction

      // Releases the first busy block of one pool at addr. Free blocks that happen to sit
      // at the same address are skipped.
      function bit release_block(bit large_pool, logic [ADDR_W-1:0] addr);
         for (int k = 0; k < pool_blocks(large_pool); k++) begin
            if (pool_address(large_pool, k) == addr && is_busy(large_pool, k)) begin
               if (large_pool) large_busy[k] = 1'b0;
               else small_busy[k] = 1'b0;
               return 1'b1;
            end
         end
         return 1'b0;
      endfunction

      function void note_request(logic mode, logic [SIZE_W-1:0] size,
                                 logic [ADDR_W-1:0] addr);
         alloc_result_type r;
         int               k;
         bit               large_pool;
         r        = '0;
         r.status = STATUS_OK;
         requests++;
         if (mode == MODE_ALLOC) begin
            if (size > LARGE_BLOCK_BYTES) begin
               r.status = STATUS_TOO_LARGE;
            end else begin
               // A full small pool never spills into the large one.
               large_pool = (size > SMALL_BLOCK_BYTES);
               k          = lowest_free(large_pool);
               if (k < 0) begin
                  r.status = STATUS_EXHAUSTED;
               end else begin
                  if (large_pool) large_busy[k] = 1'b1;
                  else small_busy[k] = 1'b1;
                  r.grant = pool_address(large_pool, k);
               end
            end
         end else if (!release_block(1'b0, addr) && !release_block(1'b1, addr)) begin
            r.status = STATUS_NOT_ALLOCATED;
         end
         r.small_map = small_busy[MAP_W-1:0];
         r.large_map = large_busy[MAP_W-1:0];
         expected_q.push_back(r);
      endfunction

      function void report(string field, logic [ADDR_W-1:0] want, logic [ADDR_W-1:0] got);
         if (mismatches < 10)
            $display("%0t: response %0d %s mismatch: expected 0x%0h, got 0x%0h",
                     $time, responses, field, want, got);
         mismatches++;
      endfunction

      function void check_response(alloc_result_type got);
         alloc_result_type want;
         responses++;
         status_seen[got.status]++;
         if (expected_q.size() == 0) begin
            if (mismatches < 10)
               $display("%0t: response %0d arrived with no request outstanding",
                        $time, responses);
            mismatches++;
         end else begin
            want = expected_q.pop_front();
            if (got.grant !== want.grant) report("grant_addr", want.grant, got.grant);
            if (got.status !== want.status)
               report("status", ADDR_W'(want.status), ADDR_W'(got.status));
            if (got.small_map !== want.small_map)
               report("small_busy_map", ADDR_W'(want.small_map), ADDR_W'(got.small_map));
            if (got.large_map !== want.large_map)
               report("large_busy_map", ADDR_W'(want.large_map), ADDR_W'(got.large_map));
         end
      endfunction

      // Picks the address of a block that is allocated right now, so that most frees in
      // the random part hit.
      function bit pick_busy_address(output logic [ADDR_W-1:0] addr);
         logic [ADDR_W-1:0] held[$];
         for (int k = 0; k < SMALL_BLOCKS; k++)
            if (small_busy[k]) held.push_back(pool_address(1'b0, k));
         for (int k = 0; k < LARGE_BLOCKS; k++)
            if (large_busy[k]) held.push_back(pool_address(1'b1, k));
         addr = '0;
         if (held.size() == 0) return 1'b0;
         addr = held[$urandom_range(held.size() - 1)];
         return 1'b1;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic                 req_mode;
   logic [SIZE_W-1:0]    req_size;
   logic [ADDR_W-1:0]    req_release_addr;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [ADDR_W-1:0]    rsp_grant_addr;
   status_type           rsp_status;
   logic [MAP_W-1:0]     rsp_small_busy_map;
   logic [MAP_W-1:0]     rsp_large_busy_map;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   alloc_scoreboard  sb;
   alloc_result_type observed;
   int               idle_pct;
   int               stall_pct;
   int               quiet_cycles;

   two_class_block_allocator #(
      .SMALL_BLOCKS      (SMALL_BLOCKS),
      .LARGE_BLOCKS      (LARGE_BLOCKS),
      .SMALL_BLOCK_BYTES (SMALL_BLOCK_BYTES),
      .LARGE_BLOCK_BYTES (LARGE_BLOCK_BYTES)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_mode           (req_mode),
      .req_size           (req_size),
      .req_release_addr   (req_release_addr),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_grant_addr     (rsp_grant_addr),
      .rsp_status         (rsp_status),
      .rsp_small_busy_map (rsp_small_busy_map),
      .rsp_large_busy_map (rsp_large_busy_map),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // The receiver decides at every falling edge whether to stall the next rising edge.
   always @(negedge clock) begin
      rsp_ready = ($urandom_range(99) >= stall_pct);
   end

   // Responses are sampled at the rising edge, before the block's own updates land.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         observed.grant     = rsp_grant_addr;
         observed.status    = rsp_status;
         observed.small_map = rsp_small_busy_map;
         observed.large_map = rsp_large_busy_map;
         sb.check_response(observed);
      end
   end

   // The watchdog ends a hung run. Any handshake on either channel counts as progress.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout: no request or response moved for %0d cycles", QUIET_LIMIT);
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // Presents one request. The sender first idles for a random number of cycles, as the
   // current pacing asks, then holds the request until the block takes it. When no gap is
   // drawn, valid stays high straight into the next request.
   task automatic send_request(input logic mode, input logic [SIZE_W-1:0] size,
                               input logic [ADDR_W-1:0] addr);
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
      @(negedge clock);
      req_valid        = 1'b1;
      req_mode         = mode;
      req_size         = size;
      req_release_addr = addr;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(mode, size, addr);
   endtask

   // The field that the operation ignores still carries random bits.
   task automatic alloc_request(input logic [SIZE_W-1:0] size);
      send_request(MODE_ALLOC, size, ADDR_W'($urandom()));
   endtask

   task automatic free_request(input logic [ADDR_W-1:0] addr);
      send_request(MODE_FREE, SIZE_W'($urandom()), addr);
   endtask

   // Drops valid and waits until every response has come back, plus the pipeline depth
   // and a margin, so that the block is idle afterward.
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_W-1:0] value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = index;
      csr_wdata = value;
      @(negedge clock);
      csr_we    = 1'b0;
      csr_wdata = CSR_W'($urandom());
      sb.write_base(index, value);
   endtask

   // Random traffic is mostly allocations across both classes, some of them oversize, and
   // frees of blocks that are really held, which keeps the pools filling and emptying. The
   // rest are frees of stray or already released addresses.
   task automatic random_request();
      int                choice;
      int                size_class;
      logic [ADDR_W-1:0] addr;
      choice = $urandom_range(99);
      if (choice < 45) begin
         size_class = $urandom_range(9);
         case (size_class) inside
            [0:3]: alloc_request(SIZE_W'($urandom_range(SMALL_BLOCK_BYTES)));
            [4:7]: alloc_request(SIZE_W'($urandom_range(LARGE_BLOCK_BYTES,
                                                      SMALL_BLOCK_BYTES + 1)));
            8: alloc_request(SIZE_W'($urandom_range(4095, LARGE_BLOCK_BYTES + 1)));
            default: begin
               case ($urandom_range(5))
                  0: alloc_request(SIZE_W'(0));
                  1: alloc_request(SIZE_W'(SMALL_BLOCK_BYTES));
                  2: alloc_request(SIZE_W'(SMALL_BLOCK_BYTES + 1));
                  3: alloc_request(SIZE_W'(LARGE_BLOCK_BYTES));
                  4: alloc_request(SIZE_W'(LARGE_BLOCK_BYTES + 1));
                  default: alloc_request(SIZE_W'(4095));
               endcase
            end
         endcase
      end else if (choice < 85) begin
         if (!sb.pick_busy_address(addr)) addr = ADDR_W'($urandom());
         free_request(addr);
      end else if (choice < 93) begin
         // A block address of either pool, whether held or not.
         if ($urandom_range(1)) addr = sb.pool_address(1'b1, $urandom_range(LARGE_BLOCKS - 1));
         else addr = sb.pool_address(1'b0, $urandom_range(SMALL_BLOCKS - 1));
         free_request(addr);
      end else begin
         free_request(ADDR_W'($urandom()));
      end
   endtask

   // One random phase: new pool bases written while the block is idle, new pacing, and a
   // stretch of random traffic.
   task automatic run_phase(input int sender_idle, input int receiver_stall,
                            input logic [CSR_W-1:0] small_base,
                            input logic [CSR_W-1:0] large_base);
      drain();
      write_csr(CSR_SMALL_POOL_BASE, small_base);
      write_csr(CSR_LARGE_POOL_BASE, large_base);
      idle_pct  = sender_idle;
      stall_pct = receiver_stall;
      repeat (PHASE_ITEMS) random_request();
   endtask

   initial begin
      logic [CSR_W-1:0] shared_base;
      sb               = new();
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_mode         = MODE_ALLOC;
      req_size         = '0;
      req_release_addr = '0;
      csr_we           = 1'b0;
      csr_index        = CSR_SMALL_POOL_BASE;
      csr_wdata        = '0;
      idle_pct         = 0;
      stall_pct        = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part with the reset bases, small pool at 0 and large pool at 1024.
      // A zero-size request is a small request, and its block at address 0 is a good grant.
      alloc_request(SIZE_W'(0));
      alloc_request(SIZE_W'(SMALL_BLOCK_BYTES));
      alloc_request(SIZE_W'(SMALL_BLOCK_BYTES + 1));
      alloc_request(SIZE_W'(LARGE_BLOCK_BYTES));
      // Oversize requests, including the widest size the port can carry.
      alloc_request(SIZE_W'(LARGE_BLOCK_BYTES + 1));
      alloc_request(SIZE_W'(4095));
      // Fill the small pool, then ask once more: it must fail even though large blocks
      // are still free.
      alloc_request(SIZE_W'(1));
      alloc_request(SIZE_W'(64));
      alloc_request(SIZE_W'(100));
      alloc_request(SIZE_W'(5));
      // Fill the large pool and overflow it too.
      alloc_request(SIZE_W'(200));
      alloc_request(SIZE_W'(255));
      alloc_request(SIZE_W'(130));
      alloc_request(SIZE_W'(LARGE_BLOCK_BYTES));
      // Release a block, release it again, and release an address no block has.
      free_request(16'd128);
      free_request(16'd128);
      free_request(16'hFFFF);
      // The freed block is the lowest free one again.
      alloc_request(SIZE_W'(64));
      free_request(16'd1024);
      drain();

      // Both pools start at 0xFF80, so addresses wrap and the pools overlap: small block 2
      // and large block 1 both sit at 0x0080, and small block 1 sits at address 0.
      write_csr(CSR_SMALL_POOL_BASE, 16'hFF80);
      write_csr(CSR_LARGE_POOL_BASE, 16'hFF80);
      // The first free takes the small block; the second skips it, now free, and takes
      // the large one; the third finds nothing left.
      free_request(16'h0080);
      free_request(16'h0080);
      free_request(16'h0080);
      alloc_request(SIZE_W'(10));
      alloc_request(SIZE_W'(SMALL_BLOCK_BYTES + 1));
      free_request(16'h0000);
      alloc_request(SIZE_W'(0));

      // Random phases, each with its own pacing and pool bases. The first two put the
      // bases at the extremes of the register range, the last makes the pools overlap.
      run_phase(0, 0, 16'h0000, 16'hFFFF);
      run_phase(85, 0, 16'hFFFF, 16'h0000);
      run_phase(0, 85, CSR_W'($urandom()), CSR_W'($urandom()));
      shared_base = CSR_W'($urandom());
      run_phase(7, 7, shared_base, shared_base);
      drain();

      $display("Covered %0d requests and %0d responses under four pacing patterns and six",
               sb.requests, sb.responses);
      $display("pool base settings: %0d granted, %0d too large, %0d class full, %0d bad frees",
               sb.status_seen[STATUS_OK], sb.status_seen[STATUS_TOO_LARGE],
               sb.status_seen[STATUS_EXHAUSTED], sb.status_seen[STATUS_NOT_ALLOCATED]);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("All tests passed");
      end else begin
         $display("%0d mismatches, %0d responses missing", sb.mismatches, sb.pending());
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
